### rtl/core/tmqm_pkg.sv
// Shared types and constants of the ticketed multi-queue manager.
// No dependencies; imported by tmqm_ticket and ticketed_multi_queue_manager.
package tmqm_pkg;

  // Default sizes, handed to the top level parameters
  localparam int NumQueuesDef  = 16;
  localparam int QueueDepthDef = 16;

  // Ticket layout offsets and masks
  localparam logic [15:0] IdxOfs    = 16'h1221;
  localparam logic [15:0] NonOfs    = 16'h0502;
  localparam logic [15:0] HighMask  = 16'h7fff;
  localparam logic [15:0] LowMask   = 16'hffff;
  localparam logic [16:0] NonceMax  = 17'h1ffff;
  localparam logic [16:0] NonceInit = 17'h00001;

  // Command codes
  typedef enum logic [1:0] {
    ModeCreate = 2'd0,
    ModeDelete = 2'd1,
    ModePut    = 2'd2,
    ModeTake   = 2'd3
  } mode_e;

  // Result status codes
  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StBad    = 3'd1,
    StEmpty  = 3'd2,
    StFull   = 3'd3,
    StNoFree = 3'd4,
    StNonce  = 3'd5
  } status_e;

  // Flags from the ticket unit to the sequencer
  typedef struct packed {
    logic in_range;   // incoming ticket names a slot inside the table
    logic nonce_ok;   // the next nonce still fits the low half
  } tk_flags_t;

endpackage

### rtl/core/tmqm_ticket.sv
// Ticket decode and compose: slot index from an incoming ticket,
// and the fresh ticket for a create. Depends on tmqm_pkg.
module tmqm_ticket import tmqm_pkg::*; #(
  parameter int NUM_QUEUES = NumQueuesDef,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic [31:0]   ticket_i,
  input  logic [QW-1:0] slot_i,
  input  logic [16:0]   nonce_cnt_i,
  output logic [QW-1:0] idx_o,
  output logic [15:0]   nonce_o,
  output logic [30:0]   new_ticket_o,
  output tk_flags_t     flags_o
);

  logic [16:0] diff;
  logic [15:0] high;
  logic [17:0] sum;

  // Decode: high half minus the index offset, no borrow and inside the table
  assign diff = {1'b0, ticket_i[31:16]} - {1'b0, IdxOfs};
  assign flags_o.in_range = !diff[16] && (diff[15:0] < 16'(NUM_QUEUES));
  assign idx_o = diff[QW-1:0];

  // Compose: slot plus offset on top, nonce counter plus offset below
  assign high = (16'(slot_i) + IdxOfs) & HighMask;
  assign sum  = {1'b0, nonce_cnt_i} + {2'b00, NonOfs};
  assign nonce_o = sum[15:0];
  assign flags_o.nonce_ok = (sum <= {2'b00, LowMask}) && (sum[15:0] != 16'd0);
  assign new_ticket_o = {high[14:0], sum[15:0]};

endmodule

### rtl/core/ticketed_multi_queue_manager.sv
// Top level of the ticketed multi-queue manager: command sequencer,
// slot table and element memory. Depends on tmqm_pkg and tmqm_ticket.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   command | in        | in_valid_i / in_ready_o | mode_i, ticket_i, value_i
//   result  | out       | out_valid_o/out_ready_i | status_o, new_ticket_o,
//           |           |                        | taken_value_o
//
// One command at a time; the element store is a single-port memory and the
// slot table has one write and one read port, both with registered reads.
// A bad index or a full table is answered from idle straight away; delete, put
// and a ticket with a wrong nonce need one slot-table read, take an element
// read as well; create scans the table from slot zero for the lowest free slot.
// After reset a clearing pass frees every slot; in_ready_o stays low meanwhile.
// A result waits in the output register while the next command is taken in;
// a stalled output only holds back the end of that command.
module ticketed_multi_queue_manager import tmqm_pkg::*; #(
  parameter int NUM_QUEUES  = NumQueuesDef,
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [31:0]        ticket_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [30:0]        new_ticket_o,
  output logic signed [31:0] taken_value_o
);

  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int DW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int CW  = $clog2(NUM_QUEUES + 1);
  localparam int EAW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  // Sequencer states
  localparam logic [2:0] SClear  = 3'd0;
  localparam logic [2:0] SIdle   = 3'd1;
  localparam logic [2:0] SScanRd = 3'd2;
  localparam logic [2:0] SScanCk = 3'd3;
  localparam logic [2:0] SMeta   = 3'd4;
  localparam logic [2:0] STake   = 3'd5;
  localparam logic [2:0] SDone   = 3'd6;

  typedef struct packed {
    logic          used;
    logic [15:0]   nonce;
    logic [DW-1:0] head;
    logic [FW-1:0] fill;
  } meta_t;

  logic [2:0]    state_q, state_d;
  logic [QW-1:0] slot_q, slot_d;
  logic [CW-1:0] used_cnt_q, used_cnt_d;
  logic [16:0]   nonce_cnt_q, nonce_cnt_d;
  logic [1:0]    mode_q, mode_d;
  logic [15:0]   tk_lo_q, tk_lo_d;
  logic [31:0]   value_q, value_d;
  status_e       res_st_q, res_st_d;
  logic [30:0]   res_tk_q, res_tk_d;
  logic [31:0]   res_val_q, res_val_d;
  logic          out_valid_q, out_valid_d;
  status_e       out_st_q, out_st_d;
  logic [30:0]   out_tk_q, out_tk_d;
  logic [31:0]   out_val_q, out_val_d;

  // Slot table and element store
  meta_t         meta_mem [NUM_QUEUES];
  meta_t         meta_rdata_q, meta_wdata, m;
  logic          meta_re, meta_we;
  logic [QW-1:0] meta_raddr, meta_waddr;
  logic [31:0]   elem_mem [NUM_QUEUES * QUEUE_DEPTH];
  logic [31:0]   elem_rdata_q;
  logic          elem_re, elem_we;
  logic [EAW-1:0] elem_addr, elem_base;
  logic [DW:0]   pos_sum;
  logic [DW-1:0] pos, head_nxt;

  logic          accept;
  logic          out_free;
  logic [QW-1:0] tk_idx;
  logic [15:0]   new_nonce;
  logic [30:0]   new_tk;
  tk_flags_t     tk_flags;

  tmqm_ticket #(
    .NUM_QUEUES(NUM_QUEUES)
  ) u_ticket (
    .ticket_i    (ticket_i),
    .slot_i      (slot_q),
    .nonce_cnt_i (nonce_cnt_q),
    .idx_o       (tk_idx),
    .nonce_o     (new_nonce),
    .new_ticket_o(new_tk),
    .flags_o     (tk_flags)
  );

  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign m          = meta_rdata_q;

  // Queue address arithmetic: base of the slot, tail position, next head
  assign elem_base = EAW'(slot_q) * EAW'(QUEUE_DEPTH);
  assign pos_sum   = (DW + 1)'(m.head) + (DW + 1)'(m.fill);
  assign pos       = (pos_sum >= (DW + 1)'(QUEUE_DEPTH)) ?
                     DW'(pos_sum - (DW + 1)'(QUEUE_DEPTH)) : pos_sum[DW-1:0];
  assign head_nxt  = (m.head == DW'(QUEUE_DEPTH - 1)) ? '0 : m.head + 1'b1;

  // Command sequencer
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    used_cnt_d  = used_cnt_q;
    nonce_cnt_d = nonce_cnt_q;
    mode_d      = mode_q;
    tk_lo_d     = tk_lo_q;
    value_d     = value_q;
    res_st_d    = res_st_q;
    res_tk_d    = res_tk_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_st_d    = out_st_q;
    out_tk_d    = out_tk_q;
    out_val_d   = out_val_q;
    meta_re     = 1'b0;
    meta_raddr  = slot_q;
    meta_we     = 1'b0;
    meta_waddr  = slot_q;
    meta_wdata  = m;
    elem_re     = 1'b0;
    elem_we     = 1'b0;
    elem_addr   = elem_base + EAW'(m.head);

    unique case (state_q)
      SClear: begin
        meta_we    = 1'b1;
        meta_wdata = '0;
        slot_d     = slot_q + 1'b1;
        if (slot_q == QW'(NUM_QUEUES - 1)) begin
          slot_d  = '0;
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (accept) begin
          mode_d    = mode_i;
          tk_lo_d   = ticket_i[15:0];
          value_d   = value_i;
          res_tk_d  = '0;
          res_val_d = '0;
          if (mode_e'(mode_i) == ModeCreate) begin
            slot_d = '0;
            if (used_cnt_q == CW'(NUM_QUEUES)) begin
              res_st_d = StNoFree;
              state_d  = SDone;
            end else begin
              state_d = SScanRd;
            end
          end else if (!tk_flags.in_range) begin
            res_st_d = StBad;
            state_d  = SDone;
          end else begin
            slot_d     = tk_idx;
            meta_re    = 1'b1;
            meta_raddr = tk_idx;
            state_d    = SMeta;
          end
        end
      end
      SScanRd: begin
        meta_re = 1'b1;
        state_d = SScanCk;
      end
      SScanCk: begin
        if (m.used) begin
          slot_d  = slot_q + 1'b1;
          state_d = SScanRd;
        end else begin
          if (nonce_cnt_q != NonceMax) begin
            nonce_cnt_d = nonce_cnt_q + 1'b1;
          end
          if (tk_flags.nonce_ok) begin
            meta_we    = 1'b1;
            meta_wdata = '{used: 1'b1, nonce: new_nonce, head: '0, fill: '0};
            used_cnt_d = used_cnt_q + 1'b1;
            res_st_d   = StOk;
            res_tk_d   = new_tk;
          end else begin
            res_st_d = StNonce;
          end
          state_d = SDone;
        end
      end
      SMeta: begin
        state_d = SDone;
        if (!m.used || (m.nonce != tk_lo_q)) begin
          res_st_d = StBad;
        end else begin
          res_st_d = StOk;
          case (mode_e'(mode_q))
            ModeDelete: begin
              meta_we         = 1'b1;
              meta_wdata.used = 1'b0;
              used_cnt_d      = used_cnt_q - 1'b1;
            end
            ModePut: begin
              if (m.fill >= FW'(QUEUE_DEPTH)) begin
                res_st_d = StFull;
              end else begin
                elem_we         = 1'b1;
                elem_addr       = elem_base + EAW'(pos);
                meta_we         = 1'b1;
                meta_wdata.fill = m.fill + 1'b1;
              end
            end
            ModeTake: begin
              if (m.fill == '0) begin
                res_st_d = StEmpty;
              end else begin
                elem_re         = 1'b1;
                meta_we         = 1'b1;
                meta_wdata.head = head_nxt;
                meta_wdata.fill = m.fill - 1'b1;
                state_d         = STake;
              end
            end
            default: res_st_d = StBad;
          endcase
        end
      end
      STake: begin
        res_val_d = elem_rdata_q;
        state_d   = SDone;
      end
      SDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_tk_d    = res_tk_q;
          out_val_d   = res_val_q;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      slot_q      <= '0;
      used_cnt_q  <= '0;
      nonce_cnt_q <= NonceInit;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      used_cnt_q  <= used_cnt_d;
      nonce_cnt_q <= nonce_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    tk_lo_q   <= tk_lo_d;
    value_q   <= value_d;
    res_st_q  <= res_st_d;
    res_tk_q  <= res_tk_d;
    res_val_q <= res_val_d;
    out_st_q  <= out_st_d;
    out_tk_q  <= out_tk_d;
    out_val_q <= out_val_d;
  end

  // Slot table: one write and one registered read
  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rdata_q <= meta_mem[meta_raddr];
    end
  end

  // Element store: single port, registered read
  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[elem_addr] <= value_q;
    end
    if (elem_re) begin
      elem_rdata_q <= elem_mem[elem_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign new_ticket_o  = out_tk_q;
  assign taken_value_o = out_val_q;

`ifndef NO_ASSERTIONS
  // One command in flight: the transfer closes the input until it finishes
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input reopened while a command is in flight");

  // Live slot count never exceeds the table
  a_used_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q <= CW'(NUM_QUEUES))
    else $error("slot count beyond table size");

  // A ticket is only reported by a successful create
  a_tk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (new_ticket_o != '0)) |-> (status_o == StOk))
    else $error("ticket reported with a failing status");

  // A taken element is only reported on success
  a_val_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (taken_value_o != '0)) |-> (status_o == StOk))
    else $error("element reported with a failing status");

  // The nonce counter starts at one and never wraps to zero
  a_nonce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonce_cnt_q != '0)
    else $error("nonce counter wrapped");
`endif

endmodule
